// ===== design/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// shared types and constants for the view record parser
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COUNT_W      = 12;
  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  // a byte is taken only while pairs held in the queue plus the one in the input stage do not pass this
  localparam int unsigned ACCEPT_LIMIT = QUEUE_DEPTH / 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 12'd4095;
  localparam logic [COUNT_W-1:0] FIXED_BYTES = 12'd30;
  localparam logic [3:0]         EDGE_BYTES  = 4'd9;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_EDGES  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 8'd1;

  localparam logic [7:0] MAX_EDGES_RESET  = 8'd16;
  localparam logic [7:0] SLOT_COUNT_RESET = 8'd64;

  typedef enum logic [3:0] {
    FIELD_SLOT        = 4'd0,
    FIELD_FROM        = 4'd1,
    FIELD_TOWARDS     = 4'd2,
    FIELD_FRACTION    = 4'd3,
    FIELD_START_YAW   = 4'd4,
    FIELD_START_PITCH = 4'd5,
    FIELD_COUNT       = 4'd6,
    FIELD_EDGE_SLOT   = 4'd7,
    FIELD_EDGE_YAW    = 4'd8,
    FIELD_EDGE_PITCH  = 4'd9,
    FIELD_END_YAW     = 4'd10,
    FIELD_END_PITCH   = 4'd11
  } field_code_t;

  typedef enum logic [2:0] {
    STATUS_OK             = 3'd0,
    STATUS_SHORT          = 3'd1,
    STATUS_LENGTH         = 3'd2,
    STATUS_SLOT_ORDER     = 3'd3,
    STATUS_SLOT_RANGE     = 3'd4,
    STATUS_EDGE_NONFINITE = 3'd5,
    STATUS_FIXED_NONFINITE = 3'd6
  } status_t;

  // results caused by one byte: an optional field and an optional verdict
  typedef struct packed {
    logic        field_valid;
    field_code_t field_code;
    logic [7:0]  edge_number;
    logic [31:0] field_value;
    logic        verdict_valid;
    status_t     status;
  } pair_t;

  function automatic logic float_nonfinite(input logic [31:0] bits);
    return &bits[30:23];
  endfunction

endpackage

// ===== design/vrp_parse.sv =====
// ----------------------------------------------------------------------------
// vrp_parse
// byte position tracking, field extraction and record checks
// ----------------------------------------------------------------------------
module vrp_parse
  import vrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  input  logic        byte_last,
  input  logic [7:0]  max_edges,
  input  logic [7:0]  slot_count,
  output logic        pair_valid,
  output pair_t       pair
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [31:0]        field_shift, field_shift_next;
  logic [7:0]         edge_total, edge_total_next;
  logic [7:0]         edge_position, edge_position_next;
  logic [3:0]         byte_in_edge, byte_in_edge_next;
  logic [7:0]         previous_edge_slot, previous_edge_slot_next;
  status_t            first_edge_fault, first_edge_fault_next;
  logic               fixed_nonfinite, fixed_nonfinite_next;

  logic               have;
  field_code_t        code;
  logic [7:0]         idx;
  logic [31:0]        value;
  logic [3:0]         bie_inc;
  logic [COUNT_W-1:0] expected_len;
  status_t            verdict;

  always_comb begin
    byte_count_next         = byte_count;
    field_shift_next        = {byte_data, field_shift[31:8]};
    edge_total_next         = edge_total;
    edge_position_next      = edge_position;
    byte_in_edge_next       = byte_in_edge;
    previous_edge_slot_next = previous_edge_slot;
    first_edge_fault_next   = first_edge_fault;
    fixed_nonfinite_next    = fixed_nonfinite;
    have    = 1'b0;
    code    = FIELD_SLOT;
    idx     = 8'd0;
    value   = 32'd0;
    bie_inc = byte_in_edge + 4'd1;

    if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + 12'd1;
    end

    if (byte_count == 12'd0) begin
      have  = 1'b1;
      code  = FIELD_SLOT;
      value = {24'd0, byte_data};
    end else if (byte_count < 12'd21) begin
      // fixed part: four-byte words end at offsets 4, 8, 12, 16 and 20
      if (byte_count[1:0] == 2'd0) begin
        have  = 1'b1;
        value = field_shift_next;
        case (byte_count[4:2])
          3'd1:    code = FIELD_FROM;
          3'd2:    code = FIELD_TOWARDS;
          3'd3:    code = FIELD_FRACTION;
          3'd4:    code = FIELD_START_YAW;
          default: code = FIELD_START_PITCH;
        endcase
        if (byte_count >= 12'd12 && float_nonfinite(field_shift_next)) begin
          fixed_nonfinite_next = 1'b1;
        end
      end
    end else if (byte_count == 12'd21) begin
      have            = 1'b1;
      code            = FIELD_COUNT;
      value           = {24'd0, byte_data};
      edge_total_next = byte_data;
    end else if (edge_position < edge_total) begin
      idx = edge_position;
      if (byte_in_edge == 4'd0) begin
        have  = 1'b1;
        code  = FIELD_EDGE_SLOT;
        value = {24'd0, byte_data};
        if (first_edge_fault == STATUS_OK) begin
          if (byte_data <= previous_edge_slot) begin
            first_edge_fault_next = STATUS_SLOT_ORDER;
          end else if (byte_data >= slot_count) begin
            first_edge_fault_next = STATUS_SLOT_RANGE;
          end
        end
        previous_edge_slot_next = byte_data;
      end else if (byte_in_edge == 4'd4 || byte_in_edge == 4'd8) begin
        have  = 1'b1;
        code  = (byte_in_edge == 4'd4) ? FIELD_EDGE_YAW : FIELD_EDGE_PITCH;
        value = field_shift_next;
        if (first_edge_fault == STATUS_OK && float_nonfinite(field_shift_next)) begin
          first_edge_fault_next = STATUS_EDGE_NONFINITE;
        end
      end
      if (bie_inc >= EDGE_BYTES) begin
        byte_in_edge_next  = 4'd0;
        edge_position_next = edge_position + 8'd1;
      end else begin
        byte_in_edge_next = bie_inc;
      end
    end else if (byte_in_edge < 4'd8) begin
      if (byte_in_edge == 4'd3 || byte_in_edge == 4'd7) begin
        have  = 1'b1;
        code  = (byte_in_edge == 4'd3) ? FIELD_END_YAW : FIELD_END_PITCH;
        value = field_shift_next;
        if (float_nonfinite(field_shift_next)) begin
          fixed_nonfinite_next = 1'b1;
        end
      end
      byte_in_edge_next = bie_inc;
    end
  end

  // verdict from the state as left by this byte
  assign expected_len = FIXED_BYTES + {1'b0, edge_total_next, 3'b000}
                      + {4'd0, edge_total_next};

  always_comb begin
    if (byte_count_next < FIXED_BYTES) begin
      verdict = STATUS_SHORT;
    end else if (edge_total_next > max_edges || byte_count_next != expected_len) begin
      verdict = STATUS_LENGTH;
    end else if (first_edge_fault_next != STATUS_OK) begin
      verdict = first_edge_fault_next;
    end else if (fixed_nonfinite_next) begin
      verdict = STATUS_FIXED_NONFINITE;
    end else begin
      verdict = STATUS_OK;
    end
  end

  always_comb begin
    pair.field_valid   = have;
    pair.field_code    = code;
    pair.edge_number   = idx;
    pair.field_value   = value;
    pair.verdict_valid = byte_last;
    pair.status        = verdict;
  end

  assign pair_valid = byte_valid && (have || byte_last);

  always_ff @(posedge clk) begin
    if (rst || (byte_valid && byte_last)) begin
      byte_count         <= '0;
      field_shift        <= '0;
      edge_total         <= '0;
      edge_position      <= '0;
      byte_in_edge       <= '0;
      previous_edge_slot <= '0;
      first_edge_fault   <= STATUS_OK;
      fixed_nonfinite    <= 1'b0;
    end else if (byte_valid) begin
      byte_count         <= byte_count_next;
      field_shift        <= field_shift_next;
      edge_total         <= edge_total_next;
      edge_position      <= edge_position_next;
      byte_in_edge       <= byte_in_edge_next;
      previous_edge_slot <= previous_edge_slot_next;
      first_edge_fault   <= first_edge_fault_next;
      fixed_nonfinite    <= fixed_nonfinite_next;
    end
  end

endmodule

// ===== design/vrp_out_queue.sv =====
// ----------------------------------------------------------------------------
// vrp_out_queue
// result pair queue, sends field then verdict of each pair
// ----------------------------------------------------------------------------
module vrp_out_queue
  import vrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pair_t             push_pair,
  output logic [QCNT_W-1:0] count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_verdict,
  output logic [3:0]        field_code,
  output logic [7:0]        edge_number,
  output logic [31:0]       field_value,
  output logic              accepted,
  output logic [2:0]        status,
  output logic              last
);

  pair_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic               field_sent;
  pair_t              head;
  logic               show_field;
  logic               pop;

  assign head       = entries[rd_ptr];
  assign show_field = head.field_valid && !field_sent;
  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready && !(show_field && head.verdict_valid);

  assign is_verdict  = !show_field;
  assign field_code  = show_field ? head.field_code : 4'd0;
  assign edge_number = show_field ? head.edge_number : 8'd0;
  assign field_value = show_field ? head.field_value : 32'd0;
  assign accepted    = !show_field && (head.status == STATUS_OK);
  assign status      = show_field ? 3'd0 : head.status;
  assign last        = show_field ? !head.verdict_valid : 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      field_sent <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr     <= rd_ptr + 1'b1;
        field_sent <= 1'b0;
      end else if (out_valid && out_ready) begin
        field_sent <= 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/view_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// view_record_parser_unit
// streaming parser and checker for one little-endian view record
// ----------------------------------------------------------------------------
// an accepted byte is registered in the input stage, then parsed into a pair that is written to the output queue
// throughput: one byte per cycle while the room check lets bytes in; a final byte
//   that also completes a field needs two output transactions, field then verdict
// the output queue of four pairs sets how far the input runs ahead of a
//   stalled consumer
// reset: synchronous, clears parse state, queue and input stage; config
//   registers return to max_edges 16 and slot_count 64
module view_record_parser_unit
  import vrp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  // payload byte channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             payload_byte,
  input  logic                   last_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_verdict,
  output logic [3:0]             field_code,
  output logic [7:0]             edge_number,
  output logic [31:0]            field_value,
  output logic                   accepted,
  output logic [2:0]             status,
  output logic                   last
);

  // config registers
  logic [7:0] max_edges;
  logic [7:0] slot_count;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  logic              pair_valid;
  pair_t             pair;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W-1:0] q_load;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_edges  <= MAX_EDGES_RESET;
      slot_count <= SLOT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_EDGES) begin
        max_edges <= cfg_data;
      end else if (cfg_index == REG_SLOT_COUNT) begin
        slot_count <= cfg_data;
      end
    end
  end

  // room check: pairs already queued plus the one in the input stage
  // leave space for this transaction even if the consumer stalls
  assign q_load   = q_count + QCNT_W'(s1_valid);
  assign in_ready = (q_load <= QCNT_W'(ACCEPT_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_ready;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= payload_byte;
      s1_last <= last_byte;
    end
  end

  // parse one byte, produce its field and verdict as a pair
  vrp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s1_valid),
    .byte_data  (s1_byte),
    .byte_last  (s1_last),
    .max_edges  (max_edges),
    .slot_count (slot_count),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  // pair queue doubles as the output register
  vrp_out_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (pair_valid),
    .push_pair   (pair),
    .count       (q_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_verdict  (is_verdict),
    .field_code  (field_code),
    .edge_number (edge_number),
    .field_value (field_value),
    .accepted    (accepted),
    .status      (status),
    .last        (last)
  );

  // queue never overflows under the room check
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    pair_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  // an accepted byte reaches the parse stage on the next edge
  a_stage_load : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted byte lost before parse");

  // a verdict is accepted exactly when its status is OK
  a_verdict_status : assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_verdict) |-> (accepted == (status == STATUS_OK)))
    else $error("verdict flag and status disagree");

  // a field item never carries a code outside the record layout
  a_field_code : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_verdict) |-> (field_code <= FIELD_END_PITCH))
    else $error("field item with undefined code");

endmodule

// ===== test/view_record_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_record_parser_checker
// watches the config, byte and result channels of the view record parser,
// predicts every field and verdict from the accepted bytes and compares
// ----------------------------------------------------------------------------
module view_record_parser_checker
  import vrp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             payload_byte,
  input  logic                   last_byte,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   is_verdict,
  input  logic [3:0]             field_code,
  input  logic [7:0]             edge_number,
  input  logic [31:0]            field_value,
  input  logic                   accepted,
  input  logic [2:0]             status,
  input  logic                   last,
  output int                     outstanding,
  output int                     failures
);

  localparam int HEAD_BYTES  = 30;
  localparam int EDGE_SPAN   = 9;
  localparam int COUNT_CEIL  = 4095;

  typedef struct packed {
    logic        is_verdict;
    field_code_t code;
    logic [7:0]  edge_number;
    logic [31:0] value;
    logic        accepted;
    status_t     status;
    logic        last;
  } view_result_t;

  view_result_t expected_results[$];

  // predictor copy of configuration and parse state
  bit [7:0]  edge_limit;
  bit [7:0]  slot_limit;
  int        byte_count;
  bit [31:0] field_shift;
  bit [7:0]  edge_total;
  bit [7:0]  edge_position;
  int        byte_in_edge;
  bit [7:0]  previous_edge_slot;
  status_t   first_edge_fault;
  bit        fixed_nonfinite;

  function automatic bit exponent_all_ones(input bit [31:0] bits);
    return bits[30:23] == 8'hFF;
  endfunction

  task automatic clear_parse();
    byte_count         = 0;
    field_shift        = '0;
    edge_total         = '0;
    edge_position      = '0;
    byte_in_edge       = 0;
    previous_edge_slot = '0;
    first_edge_fault   = STATUS_OK;
    fixed_nonfinite    = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    failures++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  task automatic expect_result(input bit verdict, input field_code_t code,
                               input bit [7:0] idx, input bit [31:0] value,
                               input bit acc, input status_t st, input bit fin);
    view_result_t r;
    r.is_verdict  = verdict;
    r.code        = code;
    r.edge_number = idx;
    r.value       = value;
    r.accepted    = acc;
    r.status      = st;
    r.last        = fin;
    expected_results.insert(expected_results.size(), r);
  endtask

  // one accepted byte: emits a completed field and, on the final byte, a verdict
  task automatic parse_byte(input bit [7:0] b, input bit fin);
    int          pos;
    bit          have;
    field_code_t code;
    bit [7:0]    idx;
    int          length;
    status_t     verdict_status;
    pos  = byte_count;
    have = 1'b0;
    code = FIELD_SLOT;
    idx  = '0;
    field_shift = {b, field_shift[31:8]};
    if (byte_count < COUNT_CEIL)
      byte_count++;

    if (pos == 0) begin
      have = 1'b1;
    end else if (pos < 21) begin
      have = (pos % 4 == 0);
      case (pos)
        4:       code = FIELD_FROM;
        8:       code = FIELD_TOWARDS;
        12:      code = FIELD_FRACTION;
        16:      code = FIELD_START_YAW;
        default: code = FIELD_START_PITCH;
      endcase
      if (have && code >= FIELD_FRACTION && exponent_all_ones(field_shift))
        fixed_nonfinite = 1'b1;
    end else if (pos == 21) begin
      have       = 1'b1;
      code       = FIELD_COUNT;
      edge_total = b;
    end else if (edge_position < edge_total) begin
      idx = edge_position;
      if (byte_in_edge == 0) begin
        have = 1'b1;
        code = FIELD_EDGE_SLOT;
        if (first_edge_fault == STATUS_OK) begin
          if (b <= previous_edge_slot)
            first_edge_fault = STATUS_SLOT_ORDER;
          else if (b >= slot_limit)
            first_edge_fault = STATUS_SLOT_RANGE;
        end
        previous_edge_slot = b;
      end else if (byte_in_edge == 4 || byte_in_edge == 8) begin
        have = 1'b1;
        if (byte_in_edge == 4)
          code = FIELD_EDGE_YAW;
        else
          code = FIELD_EDGE_PITCH;
        if (exponent_all_ones(field_shift) && first_edge_fault == STATUS_OK)
          first_edge_fault = STATUS_EDGE_NONFINITE;
      end
      byte_in_edge++;
      if (byte_in_edge >= EDGE_SPAN) begin
        byte_in_edge  = 0;
        edge_position = edge_position + 8'd1;
      end
    end else if (byte_in_edge < 8) begin
      if (byte_in_edge == 3 || byte_in_edge == 7) begin
        have = 1'b1;
        if (byte_in_edge == 3)
          code = FIELD_END_YAW;
        else
          code = FIELD_END_PITCH;
        if (exponent_all_ones(field_shift))
          fixed_nonfinite = 1'b1;
      end
      byte_in_edge++;
    end

    if (have)
      expect_result(1'b0, code, idx, (code == FIELD_SLOT || code == FIELD_COUNT ||
                    code == FIELD_EDGE_SLOT) ? {24'd0, b} : field_shift,
                    1'b0, STATUS_OK, !fin);

    if (fin) begin
      length = byte_count;
      if (length < HEAD_BYTES)
        verdict_status = STATUS_SHORT;
      else if (edge_total > edge_limit || length != HEAD_BYTES + EDGE_SPAN * int'(edge_total))
        verdict_status = STATUS_LENGTH;
      else if (first_edge_fault != STATUS_OK)
        verdict_status = first_edge_fault;
      else if (fixed_nonfinite)
        verdict_status = STATUS_FIXED_NONFINITE;
      else
        verdict_status = STATUS_OK;
      expect_result(1'b1, FIELD_SLOT, '0, '0, verdict_status == STATUS_OK,
                    verdict_status, 1'b1);
      clear_parse();
    end
  endtask

  task automatic check_result();
    view_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", field_value, '0);
    end else begin
      want = expected_results.pop_front();
      compare_field("is_verdict", 32'(is_verdict), 32'(want.is_verdict));
      compare_field("field_code", 32'(field_code), 32'(want.code));
      compare_field("edge_number", 32'(edge_number), 32'(want.edge_number));
      compare_field("field_value", field_value, want.value);
      compare_field("accepted", 32'(accepted), 32'(want.accepted));
      compare_field("status", 32'(status), 32'(want.status));
      compare_field("last", 32'(last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      edge_limit = MAX_EDGES_RESET;
      slot_limit = SLOT_COUNT_RESET;
      clear_parse();
      expected_results.delete();
    end else begin
      // a result can never come from a byte taken at the same edge
      if (out_valid && out_ready)
        check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_EDGES)
          edge_limit = cfg_data;
        else if (cfg_index == REG_SLOT_COUNT)
          slot_limit = cfg_data;
      end
      if (in_valid && in_ready)
        parse_byte(payload_byte, last_byte);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== test/view_record_parser_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_record_parser_unit_test
// drives whole and damaged view records through the parser under several
// register settings and handshake pressure; a checker beside the block
// predicts every field and verdict and counts mismatches
// ----------------------------------------------------------------------------
module view_record_parser_unit_test;
  import vrp_pkg::*;

  // cycles with no transaction on any channel before the run is given up
  localparam int QUIET_LIMIT = 4000;
  // index with no register behind it, written once to see it is ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;

  // ways a generated record is damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_SLOT_ORDER,
    FLAW_SLOT_RANGE,
    FLAW_EDGE_NONFINITE,
    FLAW_FIXED_NONFINITE,
    FLAW_TRUNCATE,
    FLAW_OVERRUN,
    FLAW_NOISE
  } flaw_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             payload_byte;
  logic                   last_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   is_verdict;
  logic [3:0]             field_code;
  logic [7:0]             edge_number;
  logic [31:0]            field_value;
  logic                   accepted;
  logic [2:0]             status;
  logic                   last;

  int outstanding;
  int failures;
  int quiet_cycles;
  int sender_idle_pct;
  int receiver_stall_pct;
  // slot_count as last written, used to shape well-formed edge slots
  int slots_configured;
  // payload under construction
  bit [7:0] record_bytes[$];

  view_record_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_verdict   (is_verdict),
    .field_code   (field_code),
    .edge_number  (edge_number),
    .field_value  (field_value),
    .accepted     (accepted),
    .status       (status),
    .last         (last)
  );

  view_record_parser_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_verdict   (is_verdict),
    .field_code   (field_code),
    .edge_number  (edge_number),
    .field_value  (field_value),
    .accepted     (accepted),
    .status       (status),
    .last         (last),
    .outstanding  (outstanding),
    .failures     (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // consumer side: stall at random as the current phase asks
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog: a long stretch with no transaction anywhere means a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drop the byte valid, wait for every predicted result, then let the
  // pipeline drain bytes that produce nothing
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // register writes only happen with the block idle; valid stays high
  // across back-to-back writes
  task automatic configure(input bit [7:0] edge_limit, input bit [7:0] slots,
                           input bit touch_spare);
    logic [CFG_INDEX_W-1:0] idx[3];
    bit [7:0]               val[3];
    int                     writes;
    wait_for_quiet();
    idx[0] = REG_SPARE;
    val[0] = 8'($urandom_range(0, 255));
    idx[1] = REG_MAX_EDGES;
    val[1] = edge_limit;
    idx[2] = REG_SLOT_COUNT;
    val[2] = slots;
    writes = 3;
    cfg_valid <= 1'b1;
    for (int i = touch_spare ? 0 : 1; i < writes; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready)
        @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    slots_configured = int'(slots);
  endtask

  // one byte transaction, with an optional idle gap in front; entered and
  // left at a falling edge so valid is assigned once per step
  task automatic send_byte(input bit [7:0] b, input bit fin);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= b;
    last_byte    <= fin;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_record();
    for (int i = 0; i < record_bytes.size(); i++)
      send_byte(record_bytes[i], i == record_bytes.size() - 1);
  endtask

  task automatic trim_record(input int keep);
    while (record_bytes.size() > keep)
      void'(record_bytes.pop_back());
  endtask

  task automatic add_byte(input bit [7:0] b);
    record_bytes.insert(record_bytes.size(), b);
  endtask

  task automatic push_word(input bit [31:0] w);
    for (int i = 0; i < 4; i++)
      add_byte(w[8*i +: 8]);
  endtask

  // random float bits; a broken one gets an all-ones exponent
  function automatic bit [31:0] pick_float(input bit broken);
    bit [31:0] v;
    v = $urandom;
    if (broken)
      v[30:23] = 8'hFF;
    else if (&v[30:23])
      v[23] = 1'b0;
    return v;
  endfunction

  // builds a little-endian record with the given edge count, then damages
  // it as the flaw asks
  task automatic build_record(input int edges_wanted, input flaw_t flaw);
    int prev;
    int room;
    int slot;
    int bad_edge;
    int bad_part;
    record_bytes.delete();
    bad_edge = (edges_wanted > 0) ? $urandom_range(0, edges_wanted - 1) : -1;
    bad_part = $urandom_range(0, 4);
    add_byte(8'($urandom_range(0, 255)));
    push_word($urandom);
    push_word($urandom);
    push_word(pick_float(flaw == FLAW_FIXED_NONFINITE && bad_part == 0));
    push_word(pick_float(flaw == FLAW_FIXED_NONFINITE && bad_part == 1));
    push_word(pick_float(flaw == FLAW_FIXED_NONFINITE && bad_part == 2));
    add_byte(edges_wanted[7:0]);
    prev = 0;
    for (int k = 0; k < edges_wanted; k++) begin
      // leave space for the slots still to come below slot_count
      room = slots_configured - 2 - prev - (edges_wanted - 1 - k);
      slot = prev + 1 + ((room > 0) ? $urandom_range(0, (room > 4) ? 4 : room) : 0);
      if (k == bad_edge && flaw == FLAW_SLOT_ORDER)
        slot = prev;                                  // repeats the previous slot
      else if (k == bad_edge && flaw == FLAW_SLOT_RANGE)
        slot = $urandom_range(slots_configured, 255); // at or above slot_count
      add_byte(slot[7:0]);
      prev = slot & 255;
      push_word(pick_float(flaw == FLAW_EDGE_NONFINITE && k == bad_edge && bad_part % 2 == 0));
      push_word(pick_float(flaw == FLAW_EDGE_NONFINITE && k == bad_edge && bad_part % 2 == 1));
    end
    push_word(pick_float(flaw == FLAW_FIXED_NONFINITE && bad_part == 3));
    push_word(pick_float(flaw == FLAW_FIXED_NONFINITE && bad_part == 4));
    case (flaw)
      FLAW_TRUNCATE: begin
        trim_record($urandom_range(1, record_bytes.size() - 1));
      end
      FLAW_OVERRUN: begin
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      end
      FLAW_NOISE: begin
        record_bytes.delete();
        repeat ($urandom_range(1, 40)) add_byte(8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
  endtask

  // mostly well-formed records with random content, the rest damaged or noise;
  // with drain set the sender waits for every result after each record
  task automatic random_traffic(input int budget, input bit drain);
    int    sent;
    int    pick;
    int    edges_wanted;
    flaw_t flaw;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      flaw = (pick < 55) ? FLAW_NONE :
             (pick < 62) ? FLAW_SLOT_ORDER :
             (pick < 69) ? FLAW_SLOT_RANGE :
             (pick < 76) ? FLAW_EDGE_NONFINITE :
             (pick < 83) ? FLAW_FIXED_NONFINITE :
             (pick < 90) ? FLAW_TRUNCATE :
             (pick < 95) ? FLAW_OVERRUN : FLAW_NOISE;
      edges_wanted = ($urandom_range(9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      build_record(edges_wanted, flaw);
      sent += record_bytes.size();
      send_record();
      if (drain)
        wait_for_quiet();
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_valid           = 1'b0;
    payload_byte       = '0;
    last_byte          = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    slots_configured   = SLOT_COUNT_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed records at the reset register values, no idling
    configure(MAX_EDGES_RESET, SLOT_COUNT_RESET, 1'b1);

    // every byte zero: all fields at their low extreme, record accepted
    record_bytes.delete();
    repeat (30) add_byte(8'h00);
    send_record();

    // every byte ones: count of 255 claimed, edges parsed, length mismatch
    record_bytes.delete();
    repeat (30) add_byte(8'hFF);
    send_record();

    // single-byte payload: slot field then a short verdict
    record_bytes.delete();
    add_byte(8'hA5);
    send_record();

    // short payloads ending on start pitch, on the count, and one byte shy
    build_record(0, FLAW_NONE);
    trim_record(21);
    send_record();
    build_record(0, FLAW_NONE);
    trim_record(22);
    send_record();
    build_record(1, FLAW_NONE);
    trim_record(29);
    send_record();

    // trailing bytes after the end view produce nothing but fail the length
    build_record(0, FLAW_OVERRUN);
    send_record();

    build_record(1, FLAW_SLOT_ORDER);
    send_record();
    build_record(1, FLAW_SLOT_RANGE);
    send_record();
    build_record(1, FLAW_EDGE_NONFINITE);
    send_record();
    build_record(0, FLAW_FIXED_NONFINITE);
    send_record();

    // range fault on edge zero and order fault on edge one: the first wins
    build_record(2, FLAW_NONE);
    record_bytes[22] = 8'd200;
    record_bytes[31] = 8'd5;
    send_record();

    // only the end pitch is nonfinite
    build_record(0, FLAW_NONE);
    record_bytes[29] = record_bytes[29] | 8'h7F;
    record_bytes[28] = record_bytes[28] | 8'h80;
    send_record();

    // zero edge limit, slot_count of one, mostly idle sender; any edge breaks the count
    configure(8'd0, 8'd1, 1'b0);
    sender_idle_pct = 80;
    random_traffic(20, 1'b0);

    // stalling consumer; the sender also waits for all results per record
    configure(8'd3, 8'd12, 1'b0);
    sender_idle_pct    = 0;
    receiver_stall_pct = 80;
    random_traffic(20, 1'b1);

    // zero slot_count fails every edge slot; light idling on both sides
    configure(8'd16, 8'd0, 1'b0);
    sender_idle_pct    = 7;
    receiver_stall_pct = 7;
    random_traffic(20, 1'b0);

    wait_for_quiet();
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
